FILE: hdl/bedw_pkg.sv
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package bedw_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HALF   = 3;
	localparam int MAX_HEIGHT = 4096;
	localparam int STORE_ROWS = 2 * MAX_HALF + 1;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WID_W  = 11;
	localparam int HGT_W  = 13;
	localparam int HALF_W = 2;
	localparam int SLOT_W = $clog2(STORE_ROWS);
	localparam int ADDR_W = $clog2(STORE_ROWS * MAX_WIDTH);
	localparam int CFG_W  = 13;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_HALF   = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SETUP = 5'b00010,
		S_READ  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_SEND  = 5'b10000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // take the input pixel, store it, set up result range
		logic win_init;   // start the window scan of the current result
		logic issue;      // read one window entry and advance the scan
		logic next_res;   // step to the next result position
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic any;        // this pixel completes at least one result
		logic win_last;   // the entry being read is the last of the window
		logic res_last;   // the current result is the last of this pixel
	} stat_t;

endpackage
`default_nettype wire

FILE: hdl/bedw_ctrl.sv
// Sequencer: accepts a pixel, then scans each result window and hands results out.
`timescale 1ns / 1ps
`default_nettype none
module bedw_ctrl
	import bedw_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  wire   out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				if (stat.any) begin
					cmd.win_init = 1'b1;
					state_d      = S_READ;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				cmd.issue = 1'b1;
				if (stat.win_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_SEND;
			end
			S_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.res_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.next_res = 1'b1;
						state_d      = S_SETUP;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

FILE: hdl/bedw_datapath.sv
// Datapath: config registers, line store, position counters and window scan.
`timescale 1ns / 1ps
`default_nettype none
module bedw_datapath
	import bedw_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire  [1:0]       cfg_idx,
	input  wire  [CFG_W-1:0] cfg_data,
	input  wire              pixel,
	input  cmd_t             cmd,
	output stat_t            stat,
	output logic             out_pixel,
	output logic [COL_W-1:0] out_col,
	output logic [ROW_W-1:0] out_row,
	output logic             run_last,
	output logic             frame_end
);

	logic              mode_q;
	logic [HALF_W-1:0] half_q;
	logic [WID_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			half_q   <= HALF_W'(1);
			width_q  <= WID_W'(640);
			height_q <= HGT_W'(480);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_MODE:   mode_q   <= cfg_data[0];
				REG_HALF:   half_q   <= cfg_data[HALF_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[WID_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [WID_W-1:0]  w;
	logic [HGT_W-1:0]  hh;
	logic [HALF_W-1:0] h;
	logic [ROW_W-1:0]  h_r;
	logic [COL_W-1:0]  h_c;
	always_comb begin
		if (width_q == '0)                    w = WID_W'(1);
		else if (width_q > WID_W'(MAX_WIDTH)) w = WID_W'(MAX_WIDTH);
		else                                  w = width_q;
		if (height_q == '0)                     hh = HGT_W'(1);
		else if (height_q > HGT_W'(MAX_HEIGHT)) hh = HGT_W'(MAX_HEIGHT);
		else                                    hh = height_q;
		h   = (half_q > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_q;
		h_r = ROW_W'(h);
		h_c = COL_W'(h);
	end

	logic [ROW_W-1:0] hh_m1;
	logic [COL_W-1:0] w_m1;
	assign hh_m1 = ROW_W'(hh - HGT_W'(1));
	assign w_m1  = COL_W'(w - WID_W'(1));

	// position of the next input pixel
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic              restart;
	logic [COL_W-1:0]  c_in;
	logic [ROW_W-1:0]  r_in;
	logic [SLOT_W-1:0] s_in;
	logic              col_wrap;
	logic              row_wrap;

	assign restart  = ({1'b0, col_q} >= w) || ({1'b0, row_q} >= hh);
	assign c_in     = restart ? '0 : col_q;
	assign r_in     = restart ? '0 : row_q;
	assign s_in     = restart ? '0 : slot_q;
	assign col_wrap = ({1'b0, c_in} + WID_W'(1)) >= w;
	assign row_wrap = ({1'b0, r_in} + HGT_W'(1)) >= hh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (cmd.load) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= r_in + ROW_W'(1);
					slot_q <= (s_in == SLOT_W'(STORE_ROWS - 1)) ? '0 : s_in + SLOT_W'(1);
				end
			end else begin
				col_q <= c_in + COL_W'(1);
			end
		end
	end

	// result range completed by this pixel
	logic [ROW_W-1:0] r0_d, r1_d;
	logic [COL_W-1:0] c0_d, c1_d;
	logic             rows_any, cols_any;
	always_comb begin
		rows_any = 1'b1;
		if (r_in == hh_m1) begin
			r0_d = (r_in >= h_r) ? r_in - h_r : '0;
			r1_d = r_in;
		end else if (r_in >= h_r) begin
			r0_d = r_in - h_r;
			r1_d = r_in - h_r;
		end else begin
			r0_d     = '0;
			r1_d     = '0;
			rows_any = 1'b0;
		end
		cols_any = 1'b1;
		if (c_in == w_m1) begin
			c0_d = (c_in >= h_c) ? c_in - h_c : '0;
			c1_d = c_in;
		end else if (c_in >= h_c) begin
			c0_d = c_in - h_c;
			c1_d = c_in - h_c;
		end else begin
			c0_d     = '0;
			c1_d     = '0;
			cols_any = 1'b0;
		end
	end

	logic [ROW_W-1:0]  r_cur_q, r1_q, rr_q;
	logic [COL_W-1:0]  c0_q, c1_q, rc_q;
	logic [SLOT_W-1:0] s_cur_q;
	logic              any_q;

	// result position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (cmd.load) begin
			any_q <= rows_any && cols_any;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_cur_q <= r_in;
			s_cur_q <= s_in;
			r1_q    <= r1_d;
			c0_q    <= c0_d;
			c1_q    <= c1_d;
			rr_q    <= r0_d;
			rc_q    <= c0_d;
		end else if (cmd.next_res) begin
			if (rc_q == c1_q) begin
				rc_q <= c0_q;
				rr_q <= rr_q + ROW_W'(1);
			end else begin
				rc_q <= rc_q + COL_W'(1);
			end
		end
	end

	// window scan counters
	logic [ROW_W-1:0] wr_q, wr1_q;
	logic [COL_W-1:0] wc_q, wc0_q, wc1_q;
	logic [HGT_W-1:0] rr_hi;
	logic [WID_W-1:0] rc_hi;
	assign rr_hi = HGT_W'(rr_q) + HGT_W'(h);
	assign rc_hi = WID_W'(rc_q) + WID_W'(h);

	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			wr_q  <= (rr_q >= h_r) ? rr_q - h_r : '0;
			wr1_q <= (rr_hi < hh) ? ROW_W'(rr_hi) : hh_m1;
			wc_q  <= (rc_q >= h_c) ? rc_q - h_c : '0;
			wc0_q <= (rc_q >= h_c) ? rc_q - h_c : '0;
			wc1_q <= (rc_hi < w) ? COL_W'(rc_hi) : w_m1;
		end else if (cmd.issue) begin
			if (wc_q == wc1_q) begin
				wc_q <= wc0_q;
				wr_q <= wr_q + ROW_W'(1);
			end else begin
				wc_q <= wc_q + COL_W'(1);
			end
		end
	end

	// store slot of the window row: it lies at most 2*MAX_HALF rows back
	logic [ROW_W-1:0]  d_full;
	logic [SLOT_W-1:0] d;
	logic [SLOT_W-1:0] s_rd;
	assign d_full = r_cur_q - wr_q;
	assign d      = d_full[SLOT_W-1:0];
	assign s_rd   = (s_cur_q >= d) ? s_cur_q - d : SLOT_W'(s_cur_q + SLOT_W'(STORE_ROWS) - d);

	// line store
	logic              row_store_q [STORE_ROWS*MAX_WIDTH];
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              rdata_s1;
	logic              rvalid_s1;
	assign wr_addr = ADDR_W'(s_in) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_in);
	assign rd_addr = ADDR_W'(s_rd) * ADDR_W'(MAX_WIDTH) + ADDR_W'(wc_q);

	always_ff @(posedge clk) begin
		if (cmd.load) row_store_q[wr_addr] <= pixel;
		rdata_s1 <= row_store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rvalid_s1 <= 1'b0;
		else         rvalid_s1 <= cmd.issue;
	end

	// window reduction: AND for erosion, OR for dilation
	logic acc_q;
	always_ff @(posedge clk) begin
		if (cmd.win_init)  acc_q <= ~mode_q;
		else if (rvalid_s1) acc_q <= mode_q ? (acc_q | rdata_s1) : (acc_q & rdata_s1);
	end

	assign stat.any      = any_q;
	assign stat.win_last = (wr_q == wr1_q) && (wc_q == wc1_q);
	assign stat.res_last = (rr_q == r1_q) && (rc_q == c1_q);

	assign out_pixel = acc_q;
	assign out_col   = rc_q;
	assign out_row   = rr_q;
	assign run_last  = stat.res_last;
	assign frame_end = (rr_q == hh_m1) && (rc_q == w_m1);

endmodule
`default_nettype wire

FILE: hdl/binary_erode_dilate_window_top.sv
// Top level: binary erosion/dilation over a square window on a raster pixel stream.
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           tdata[0] pixel
//  m_axis    out        tvalid/tready           tdata out_pixel,out_col,out_row; tlast; tuser
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One pixel at a time: the block accepts a pixel, then a setup state checks whether it completes any result.
// Each result takes a setup state, one store read per window entry ((2h+1)^2 or
// fewer, single read port), a drain state and an output state held until the result is taken.
// Reset needs no store clearing.
// A stalled result holds the block until taken; config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
module binary_erode_dilate_window_top
	import bedw_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [0] pixel, [7:1] zero
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] out_pixel, [10:1] out_col, [22:11] out_row
	output logic        m_axis_tlast,   // run_last
	output logic        m_axis_tuser,   // [0] frame_end
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [12:0] cfg_data
);

	cmd_t             cmd;
	stat_t            stat;
	logic             out_pixel;
	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;

	assign cfg_ready = 1'b1;

	bedw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bedw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (s_axis_tdata[0]),
		.cmd       (cmd),
		.stat      (stat),
		.out_pixel (out_pixel),
		.out_col   (out_col),
		.out_row   (out_row),
		.run_last  (m_axis_tlast),
		.frame_end (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, out_row, out_col, out_pixel};

	// only one transaction in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && s_axis_tready))
		else $error("input ready while a result is pending");

	// the frame's final result always closes its run
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("frame end without run last");

	// an accepted pixel blocks the input for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after accept");

endmodule
`default_nettype wire

FILE: verif/binary_erode_dilate_window_top_tb.sv
// Testbench for binary_erode_dilate_window_top: directed table, then random frames vs. a predictor.
`timescale 1ns / 1ps
`default_nettype none
module binary_erode_dilate_window_top_tb;
	import bedw_pkg::*;

	typedef struct packed {
		bit        pix;
		bit [9:0]  col;
		bit [11:0] row;
		bit        last;
		bit        fend;
	} morph_res_t;

	typedef struct {
		bit         is_cfg;
		reg_idx_t   idx;
		bit [12:0]  val;
		bit         pix;
		bit         fixed;
		morph_res_t fx;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	binary_erode_dilate_window_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block state
	bit         line_mem [STORE_ROWS][MAX_WIDTH];
	int         cur_col, cur_row;
	bit         sh_mode;
	bit [1:0]   sh_half;
	bit [10:0]  sh_width;
	bit [12:0]  sh_height;
	morph_res_t pending_q[$];
	int         mismatches;
	int         send_idle, recv_idle;
	int         pixels_sent;
	bit         fix_en;
	morph_res_t fix_val;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#20ms;
		$display("binary_erode_dilate_window_top_tb: errors");
		$finish;
	end

	function automatic int act_width();
		if (sh_width == 0) return 1;
		if (sh_width > MAX_WIDTH) return MAX_WIDTH;
		return sh_width;
	endfunction

	function automatic int act_height();
		if (sh_height == 0) return 1;
		if (sh_height > MAX_HEIGHT) return MAX_HEIGHT;
		return sh_height;
	endfunction

	// AND / OR over the clipped window around (r,c)
	function automatic bit window_op(int r, int c, int h, int w, int hh);
		int rr, cc;
		bit acc;
		acc = !sh_mode;
		for (rr = (r >= h ? r - h : 0); rr <= (r + h < hh ? r + h : hh - 1); rr++)
			for (cc = (c >= h ? c - h : 0); cc <= (c + h < w ? c + h : w - 1); cc++)
				if (sh_mode) acc |= line_mem[rr % STORE_ROWS][cc];
				else acc &= line_mem[rr % STORE_ROWS][cc];
		return acc;
	endfunction

	// store one pixel and queue every result it completes
	function automatic void morph_predict(bit p);
		int w, hh, h, r0, r1, c0, c1, r, c;
		bit rows_ok, cols_ok;
		morph_res_t e;
		w = act_width();
		hh = act_height();
		h = sh_half;
		if (cur_col >= w || cur_row >= hh) begin
			cur_col = 0;
			cur_row = 0;
		end
		line_mem[cur_row % STORE_ROWS][cur_col] = p;
		rows_ok = 1;
		cols_ok = 1;
		if (cur_row == hh - 1) begin
			r0 = cur_row >= h ? cur_row - h : 0; r1 = cur_row;
		end else if (cur_row >= h) begin
			r0 = cur_row - h; r1 = r0;
		end else rows_ok = 0;
		if (cur_col == w - 1) begin
			c0 = cur_col >= h ? cur_col - h : 0; c1 = cur_col;
		end else if (cur_col >= h) begin
			c0 = cur_col - h; c1 = c0;
		end else cols_ok = 0;
		if (rows_ok && cols_ok)
			for (r = r0; r <= r1; r++)
				for (c = c0; c <= c1; c++) begin
					e.pix = window_op(r, c, h, w, hh);
					e.col = 10'(c);
					e.row = 12'(r);
					e.last = (r == r1 && c == c1);
					e.fend = (r == hh - 1 && c == w - 1);
					pending_q.push_back(e);
				end
		if (cur_col + 1 >= w) begin
			cur_col = 0;
			cur_row = (cur_row + 1 >= hh) ? 0 : cur_row + 1;
		end else cur_col++;
	endfunction

	// one pixel transaction; valid drops only on a gap or at the end of a burst
	task automatic push_pixel(bit p, bit last_one);
		s_axis_tdata <= {7'd0, p};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		morph_predict(p);
		// a typed-in expectation replaces the predicted one at the accepting edge
		if (fix_en) begin
			void'(pending_q.pop_back());
			pending_q.push_back(fix_val);
			fix_en = 1'b0;
		end
		pixels_sent++;
		if (last_one || $urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			if (!last_one)
				do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
	endtask

	// hold off until every expected result is taken, then let the block settle
	task automatic drain_results();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, bit [12:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		unique case (idx)
			REG_MODE:   sh_mode = val[0];
			REG_HALF:   sh_half = val[1:0];
			REG_WIDTH:  sh_width = val[10:0];
			REG_HEIGHT: sh_height = val;
		endcase
		@(posedge clk);
	endtask

	// a run of pixels at the current geometry
	task automatic send_pixels(int n);
		int i, dens;
		dens = sh_mode ? 20 : 80;
		for (i = 0; i < n; i++)
			push_pixel($urandom_range(0, 99) < dens, i == n - 1);
	endtask

	// whole frames at the current geometry
	task automatic send_frames(int nframes);
		send_pixels(nframes * act_width() * act_height());
	endtask

	task automatic setup_phase(bit m, bit [1:0] hf, bit [10:0] w, bit [12:0] hgt);
		drain_results();
		write_reg(REG_MODE, 13'(m));
		write_reg(REG_HALF, 13'(hf));
		write_reg(REG_WIDTH, 13'(w));
		write_reg(REG_HEIGHT, hgt);
	endtask

	// result side: random backpressure and field compare
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result tdata=%h tlast=%b tuser=%b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				morph_res_t e;
				e = pending_q.pop_front();
				if (m_axis_tdata[0] !== e.pix || m_axis_tdata[10:1] !== e.col ||
						m_axis_tdata[22:11] !== e.row || m_axis_tlast !== e.last ||
						m_axis_tuser !== e.fend) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp %b %0d %0d %b %b got %b %0d %0d %b %b",
							e.pix, e.col, e.row, e.last, e.fend, m_axis_tdata[0],
							m_axis_tdata[10:1], m_axis_tdata[22:11], m_axis_tlast,
							m_axis_tuser);
				end
			end
		end
	end

	// directed rows: tiny frames, both modes, full half width, geometry shrink past position
	stim_row_t dir_tab[28] = '{
		'{1, REG_MODE,   13'd0, 0, 0, '0},
		'{1, REG_HALF,   13'd0, 0, 0, '0},
		'{1, REG_WIDTH,  13'd1, 0, 0, '0},
		'{1, REG_HEIGHT, 13'd1, 0, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 1, '{1'b1, 10'd0, 12'd0, 1'b1, 1'b1}},
		'{0, REG_MODE,   13'd0, 0, 1, '{1'b0, 10'd0, 12'd0, 1'b1, 1'b1}},
		'{1, REG_MODE,   13'd1, 0, 0, '0},
		'{0, REG_MODE,   13'd0, 0, 1, '{1'b0, 10'd0, 12'd0, 1'b1, 1'b1}},
		'{0, REG_MODE,   13'd0, 1, 1, '{1'b1, 10'd0, 12'd0, 1'b1, 1'b1}},
		'{1, REG_HALF,   13'd3, 0, 0, '0},
		'{1, REG_WIDTH,  13'd3, 0, 0, '0},
		'{1, REG_HEIGHT, 13'd2, 0, 0, '0},
		'{1, REG_MODE,   13'd0, 0, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 0, 0, '0},
		'{1, REG_WIDTH,  13'd8, 0, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 0, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{1, REG_WIDTH,  13'd2, 0, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0},
		'{0, REG_MODE,   13'd0, 0, 0, '0},
		'{0, REG_MODE,   13'd0, 1, 0, '0}
	};

	initial begin
		int i, seg;
		bit [10:0] w;
		bit [12:0] hg;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		mismatches = 0;
		pixels_sent = 0;
		fix_en = 1'b0;
		fix_val = '0;
		cur_col = 0;
		cur_row = 0;
		sh_mode = 0;
		sh_half = 1;
		sh_width = 640;
		sh_height = 480;
		send_idle = 20;
		recv_idle = 74;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < 28; i++) begin
			if (dir_tab[i].is_cfg) begin
				drain_results();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				fix_en = dir_tab[i].fixed;
				fix_val = dir_tab[i].fx;
				push_pixel(dir_tab[i].pix, i == 27 || dir_tab[i + 1].is_cfg);
			end
		end

		// random frames under three idling regimes
		for (seg = 0; seg < 3; seg++) begin
			send_idle = (seg == 0) ? 20 : (seg == 1) ? 74 : 0;
			recv_idle = (seg == 0) ? 74 : (seg == 1) ? 20 : 0;
			pixels_sent = 0;
			while (pixels_sent < 40) begin
				w = 11'($urandom_range(1, 8));
				hg = 13'($urandom_range(1, 6));
				if ($urandom_range(0, 9) == 0) w = 0;
				if ($urandom_range(0, 9) == 0) hg = 0;
				setup_phase(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), w, hg);
				send_frames(int'($urandom_range(1, 3)));
			end
		end

		// geometry past the limits: a short run of each, next setup restarts the frame
		setup_phase(1'($urandom_range(0, 1)), 2'd3, 11'd2047, 13'd1);
		send_pixels(24);
		setup_phase(1'($urandom_range(0, 1)), 2'd2, 11'd2, 13'd8191);
		send_pixels(24);

		drain_results();
		if (mismatches == 0 && pending_q.size() == 0)
			$display("binary_erode_dilate_window_top_tb: clean");
		else
			$display("binary_erode_dilate_window_top_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
